// ----- hw/rtl/pit_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

    localparam int AXES  = 3;
    localparam int EDGES = 3;

    typedef logic [EDGES-1:0] edge_mask_t;

endpackage

`default_nettype wire

// ----- hw/rtl/point_in_triangle_test_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// pipeline: an input transfer reaches result valid through the seven register stages
// (unpack/subtract, cross products, cross difference, split dot products, recombine, sum, sign)
// throughput: one test per cycle while the output is not stalled; a stalled output holds the whole pipeline in place
// reset: aresetn clears the stage valid bits only, payload registers are not reset

module point_in_triangle_test_top
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  wire                       aclk,
    input  wire                       aresetn,

    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire [3*COORD_WIDTH-1:0]   s_test_point,
    input  wire [3*COORD_WIDTH-1:0]   s_plane_normal,
    input  wire [3*COORD_WIDTH-1:0]   s_vertex_a,
    input  wire [3*COORD_WIDTH-1:0]   s_vertex_b,
    input  wire [3*COORD_WIDTH-1:0]   s_vertex_c,

    output logic                      m_valid,
    input  wire                       m_ready,
    output logic                      m_inside_res,
    output edge_mask_t                m_edge_nonneg,
    output edge_mask_t                m_edge_nonpos
);

    localparam int W      = COORD_WIDTH;
    localparam int DW     = W + 1;          // coordinate difference
    localparam int PW     = DW + W;         // difference times normal
    localparam int MW     = PW + 1;         // cross product component
    localparam int LO_W   = DW;             // low slice of cross component
    localparam int HI_W   = MW - LO_W;      // high slice, signed
    localparam int LP_W   = LO_W + 1 + DW;  // low partial product
    localparam int HP_W   = HI_W + DW;      // high partial product
    localparam int TW     = MW + DW;        // one dot product term
    localparam int SW     = TW + 2;         // edge value
    localparam int STAGES = 7;

    logic [STAGES-1:0] vld_reg;
    logic              adv;

    assign adv     = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    // stage 1: unpack and form edge and point differences
    logic signed [W-1:0]  pt     [AXES];
    logic signed [W-1:0]  nrm    [AXES];
    logic signed [W-1:0]  vtx    [EDGES][AXES];
    logic signed [DW-1:0] ed_next [EDGES][AXES];
    logic signed [DW-1:0] pd_next [EDGES][AXES];
    logic signed [DW-1:0] ed_reg  [EDGES][AXES];
    logic signed [DW-1:0] pd1_reg [EDGES][AXES];
    logic signed [W-1:0]  n_reg   [AXES];

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            pt[i]     = $signed(s_test_point[i*W +: W]);
            nrm[i]    = $signed(s_plane_normal[i*W +: W]);
            vtx[0][i] = $signed(s_vertex_a[i*W +: W]);
            vtx[1][i] = $signed(s_vertex_b[i*W +: W]);
            vtx[2][i] = $signed(s_vertex_c[i*W +: W]);
        end
        for (int e = 0; e < EDGES; e++) begin
            for (int i = 0; i < AXES; i++) begin
                ed_next[e][i] = DW'(vtx[(e == EDGES-1) ? 0 : e+1][i]) - DW'(vtx[e][i]);
                pd_next[e][i] = DW'(pt[i]) - DW'(vtx[e][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ed_reg  <= ed_next;
            pd1_reg <= pd_next;
            n_reg   <= nrm;
        end
    end

    // stage 2: six products per edge for (end - start) x normal
    logic signed [PW-1:0] prod_next [EDGES][AXES][2];
    logic signed [PW-1:0] prod_reg  [EDGES][AXES][2];
    logic signed [DW-1:0] pd2_reg   [EDGES][AXES];

    always_comb begin
        for (int e = 0; e < EDGES; e++) begin
            for (int k = 0; k < AXES; k++) begin
                prod_next[e][k][0] = PW'(ed_reg[e][(k + 1) % AXES])
                                   * PW'(n_reg[(k + 2) % AXES]);
                prod_next[e][k][1] = PW'(ed_reg[e][(k + 2) % AXES])
                                   * PW'(n_reg[(k + 1) % AXES]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            pd2_reg  <= pd1_reg;
        end
    end

    // stage 3: cross product components
    logic signed [MW-1:0] m_next  [EDGES][AXES];
    logic signed [MW-1:0] m_reg   [EDGES][AXES];
    logic signed [DW-1:0] pd3_reg [EDGES][AXES];

    always_comb begin
        for (int e = 0; e < EDGES; e++) begin
            for (int k = 0; k < AXES; k++) begin
                m_next[e][k] = MW'(prod_reg[e][k][0]) - MW'(prod_reg[e][k][1]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg   <= m_next;
            pd3_reg <= pd2_reg;
        end
    end

    // stage 4: dot product terms split into low and high partial products
    logic signed [LP_W-1:0] lo_next [EDGES][AXES];
    logic signed [HP_W-1:0] hi_next [EDGES][AXES];
    logic signed [LP_W-1:0] lo_reg  [EDGES][AXES];
    logic signed [HP_W-1:0] hi_reg  [EDGES][AXES];

    always_comb begin
        for (int e = 0; e < EDGES; e++) begin
            for (int k = 0; k < AXES; k++) begin
                lo_next[e][k] = LP_W'($signed({1'b0, m_reg[e][k][LO_W-1:0]}))
                              * LP_W'(pd3_reg[e][k]);
                hi_next[e][k] = HP_W'($signed(m_reg[e][k][MW-1:LO_W]))
                              * HP_W'(pd3_reg[e][k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // stage 5: recombine the partial products
    logic signed [TW-1:0] term_next [EDGES][AXES];
    logic signed [TW-1:0] term_reg  [EDGES][AXES];

    always_comb begin
        for (int e = 0; e < EDGES; e++) begin
            for (int k = 0; k < AXES; k++) begin
                term_next[e][k] = (TW'(hi_reg[e][k]) <<< LO_W) + TW'(lo_reg[e][k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            term_reg <= term_next;
        end
    end

    // stage 6: edge values
    logic signed [SW-1:0] d_next [EDGES];
    logic signed [SW-1:0] d_reg  [EDGES];

    always_comb begin
        for (int e = 0; e < EDGES; e++) begin
            d_next[e] = SW'(term_reg[e][0]) + SW'(term_reg[e][1]) + SW'(term_reg[e][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg <= d_next;
        end
    end

    // stage 7: sign tests, zero counts on both sides
    edge_mask_t nonneg_next;
    edge_mask_t nonpos_next;
    logic       inside_next;
    logic       inside_reg;
    edge_mask_t nonneg_reg;
    edge_mask_t nonpos_reg;

    always_comb begin
        for (int e = 0; e < EDGES; e++) begin
            nonneg_next[e] = !d_reg[e][SW-1];
            nonpos_next[e] = d_reg[e][SW-1] || (d_reg[e] == '0);
        end
        inside_next = (&nonneg_next) || (&nonpos_next);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            inside_reg <= inside_next;
            nonneg_reg <= nonneg_next;
            nonpos_reg <= nonpos_next;
        end
    end

    assign m_inside_res  = inside_reg;
    assign m_edge_nonneg = nonneg_reg;
    assign m_edge_nonpos = nonpos_reg;

    a_inside_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_inside_res == ((&m_edge_nonneg) || (&m_edge_nonpos))))
        else $error("inside flag disagrees with edge masks");

    a_edge_covered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_edge_nonneg | m_edge_nonpos) == {EDGES{1'b1}}))
        else $error("edge value neither non-negative nor non-positive");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

    a_transfer_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted transfer missing from first stage");

endmodule

`default_nettype wire

// ----- verif/tb_point_in_triangle_test_top.sv -----
`timescale 1ns / 1ps

module tb_point_in_triangle_test_top;
    import pit_pkg::*;

    localparam int CW          = 16;
    localparam int VW          = 3 * CW;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 24;
    localparam int RAND_PER_PHASE = 417;

    typedef longint vec_t [AXES];

    typedef struct packed {
        logic       in_tri;
        edge_mask_t nonneg;
        edge_mask_t nonpos;
    } verdict_t;

    typedef struct packed {
        logic [VW-1:0] p;
        logic [VW-1:0] n;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic [VW-1:0] c;
        logic          typed;
        verdict_t      res;
    } query_row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [VW-1:0] s_test_point = '0;
    logic [VW-1:0] s_plane_normal = '0;
    logic [VW-1:0] s_vertex_a = '0;
    logic [VW-1:0] s_vertex_b = '0;
    logic [VW-1:0] s_vertex_c = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_inside_res;
    edge_mask_t    m_edge_nonneg;
    edge_mask_t    m_edge_nonpos;

    verdict_t pending_verdicts [$];
    int       src_idle_pct = 28;
    int       snk_idle_pct = 81;
    int       stall_cycles = 0;
    int       fail_count = 0;
    int       results_seen = 0;
    int       inside_seen = 0;
    int       on_line_seen = 0;

    localparam verdict_t ALL_ZERO = '{in_tri: 1'b1, nonneg: 3'b111, nonpos: 3'b111};

    // x in the low 16 bits, then y, then z
    query_row_t stim_rows [16] = '{
        '{48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 1'b1, ALL_ZERO},
        '{48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff,
          48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 1'b1, ALL_ZERO},
        '{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
          48'h8000_8000_8000, 48'h8000_8000_8000, 1'b1, ALL_ZERO},
        '{48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
          48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 1'b1, ALL_ZERO},
        // zero normal with a real triangle
        '{48'h1234_8000_7fff, 48'h0, 48'h8000_0000_7fff,
          48'h7fff_8000_0001, 48'h0000_7fff_8000, 1'b1, ALL_ZERO},
        // right triangle in the xy plane: inside, outside, on an edge, on a vertex
        '{48'h0000_000a_000a, 48'h0001_0000_0000, 48'h0,
          48'h0000_0000_0064, 48'h0000_0064_0000, 1'b0, '0},
        '{48'h0000_00c8_00c8, 48'h0001_0000_0000, 48'h0,
          48'h0000_0000_0064, 48'h0000_0064_0000, 1'b0, '0},
        '{48'h0000_0000_0032, 48'h0001_0000_0000, 48'h0,
          48'h0000_0000_0064, 48'h0000_0064_0000, 1'b0, '0},
        '{48'h0, 48'h0001_0000_0000, 48'h0,
          48'h0000_0000_0064, 48'h0000_0064_0000, 1'b0, '0},
        // flipped normal
        '{48'h0000_000a_000a, 48'hffff_0000_0000, 48'h0,
          48'h0000_0000_0064, 48'h0000_0064_0000, 1'b0, '0},
        // collinear vertices
        '{48'h0000_0000_0005, 48'h0003_0002_0001, 48'h0,
          48'h000a_000a_000a, 48'h0014_0014_0014, 1'b0, '0},
        // full-scale coordinates, largest products
        '{48'h0, 48'h7fff_8000_7fff, 48'h8000_8000_8000,
          48'h7fff_7fff_7fff, 48'h8000_7fff_8000, 1'b0, '0},
        '{48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'h8000_8000_8000,
          48'h0, 48'h8000_0000_7fff, 1'b0, '0},
        '{48'h8000_8000_8000, 48'h7fff_7fff_7fff, 48'h7fff_8000_7fff,
          48'h8000_7fff_8000, 48'h8000_7fff_7fff, 1'b0, '0},
        // point lifted off the plane along the normal
        '{48'h01f4_000a_000a, 48'h0001_0000_0000, 48'h0,
          48'h0000_0000_0064, 48'h0000_0064_0000, 1'b0, '0},
        '{48'hffff_ffff_ffff, 48'h0001_0000_0000, 48'h0000_ff9c_ff9c,
          48'h0000_ff9c_0064, 48'h0000_0064_0000, 1'b0, '0}
    };

    point_in_triangle_test_top #(.COORD_WIDTH(CW)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_test_point   (s_test_point),
        .s_plane_normal (s_plane_normal),
        .s_vertex_a     (s_vertex_a),
        .s_vertex_b     (s_vertex_b),
        .s_vertex_c     (s_vertex_c),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inside_res   (m_inside_res),
        .m_edge_nonneg  (m_edge_nonneg),
        .m_edge_nonpos  (m_edge_nonpos)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic vec_t unpack_vec(input logic [VW-1:0] packed_v);
        vec_t r;
        for (int i = 0; i < AXES; i++) begin
            r[i] = longint'($signed(packed_v[i*CW +: CW]));
        end
        return r;
    endfunction

    // (end - start) x normal, dotted with (point - start)
    function automatic longint edge_distance(input vec_t p, input vec_t n,
                                             input vec_t s, input vec_t e);
        vec_t d;
        vec_t q;
        vec_t m;
        for (int i = 0; i < AXES; i++) begin
            d[i] = e[i] - s[i];
            q[i] = p[i] - s[i];
        end
        m[0] = d[1] * n[2] - d[2] * n[1];
        m[1] = d[2] * n[0] - d[0] * n[2];
        m[2] = d[0] * n[1] - d[1] * n[0];
        return m[0] * q[0] + m[1] * q[1] + m[2] * q[2];
    endfunction

    function automatic verdict_t classify_point(input logic [VW-1:0] p, input logic [VW-1:0] n,
                                                input logic [VW-1:0] a, input logic [VW-1:0] b,
                                                input logic [VW-1:0] c);
        vec_t     verts [EDGES];
        vec_t     pv;
        vec_t     nv;
        longint   edge_val;
        verdict_t r;
        pv = unpack_vec(p);
        nv = unpack_vec(n);
        verts[0] = unpack_vec(a);
        verts[1] = unpack_vec(b);
        verts[2] = unpack_vec(c);
        r = '0;
        for (int i = 0; i < EDGES; i++) begin
            edge_val = edge_distance(pv, nv, verts[i], verts[(i + 1) % EDGES]);
            r.nonneg[i] = (edge_val >= 0);
            r.nonpos[i] = (edge_val <= 0);
        end
        r.in_tri = (&r.nonneg) | (&r.nonpos);
        return r;
    endfunction

    function automatic logic [VW-1:0] pack_vec(input int x, input int y, input int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic int rand_coord(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic logic [CW-1:0] corner_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [VW-1:0] corner_vec();
        return {corner_coord(), corner_coord(), corner_coord()};
    endfunction

    function automatic logic [VW-1:0] rand_vec();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    task automatic send_query(input logic [VW-1:0] p, input logic [VW-1:0] n,
                              input logic [VW-1:0] a, input logic [VW-1:0] b,
                              input logic [VW-1:0] c, input logic typed,
                              input verdict_t typed_res);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_test_point   <= p;
        s_plane_normal <= n;
        s_vertex_a     <= a;
        s_vertex_b     <= b;
        s_vertex_c     <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_verdicts.push_back(typed ? typed_res : classify_point(p, n, a, b, c));
    endtask

    // mostly consistent triangles with their own normal, some noise on top
    task automatic send_random_query();
        int av [3];
        int bv [3];
        int cv [3];
        int pv [3];
        int nv [3];
        int scale;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            for (int i = 0; i < 3; i++) begin
                av[i] = rand_coord(60);
                bv[i] = rand_coord(60);
                cv[i] = rand_coord(60);
            end
            nv[0] = (bv[1]-av[1])*(cv[2]-av[2]) - (bv[2]-av[2])*(cv[1]-av[1]);
            nv[1] = (bv[2]-av[2])*(cv[0]-av[0]) - (bv[0]-av[0])*(cv[2]-av[2]);
            nv[2] = (bv[0]-av[0])*(cv[1]-av[1]) - (bv[1]-av[1])*(cv[0]-av[0]);
            if ($urandom_range(0, 3) == 0) begin
                for (int i = 0; i < 3; i++) nv[i] = -nv[i];
            end
            case ($urandom_range(0, 5))
                0: for (int i = 0; i < 3; i++) pv[i] = av[i];
                1: for (int i = 0; i < 3; i++) pv[i] = (av[i] + bv[i]) / 2;
                2, 3: for (int i = 0; i < 3; i++)
                    pv[i] = (av[i] + bv[i] + cv[i]) / 3 + rand_coord(8);
                default: for (int i = 0; i < 3; i++) pv[i] = rand_coord(64);
            endcase
            // spread over the full coordinate range without changing the geometry
            scale = ($urandom_range(0, 1) == 1) ? int'($urandom_range(2, 470)) : 1;
            for (int i = 0; i < 3; i++) begin
                av[i] *= scale;
                bv[i] *= scale;
                cv[i] *= scale;
                pv[i] *= scale;
            end
            send_query(pack_vec(pv[0], pv[1], pv[2]), pack_vec(nv[0], nv[1], nv[2]),
                       pack_vec(av[0], av[1], av[2]), pack_vec(bv[0], bv[1], bv[2]),
                       pack_vec(cv[0], cv[1], cv[2]), 1'b0, '0);
        end else if (pick < 80) begin
            send_query(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec(), 1'b0, '0);
        end else if (pick < 92) begin
            send_query(corner_vec(), corner_vec(), corner_vec(), corner_vec(), corner_vec(),
                       1'b0, '0);
        end else begin
            // zero normal or a triangle with a repeated vertex
            if ($urandom_range(0, 1) == 1)
                send_query(rand_vec(), '0, rand_vec(), rand_vec(), rand_vec(), 1'b0, '0);
            else begin
                for (int i = 0; i < 3; i++) av[i] = rand_coord(32767);
                send_query(rand_vec(), rand_vec(), pack_vec(av[0], av[1], av[2]),
                           pack_vec(av[0], av[1], av[2]), rand_vec(), 1'b0, '0);
            end
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else if (m_valid && m_ready) begin
                results_seen++;
                if (m_inside_res) inside_seen++;
                if ((m_edge_nonneg & m_edge_nonpos) != '0) on_line_seen++;
                if (pending_verdicts.size() == 0) begin
                    $error("result with no test outstanding");
                    fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (m_inside_res !== want.in_tri) begin
                        $error("inside_res: expected %0b, got %0b", want.in_tri, m_inside_res);
                        fail_count++;
                    end
                    if (m_edge_nonneg !== want.nonneg) begin
                        $error("edge_nonneg: expected %03b, got %03b",
                               want.nonneg, m_edge_nonneg);
                        fail_count++;
                    end
                    if (m_edge_nonpos !== want.nonpos) begin
                        $error("edge_nonpos: expected %03b, got %03b",
                               want.nonpos, m_edge_nonpos);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            send_query(stim_rows[i].p, stim_rows[i].n, stim_rows[i].a, stim_rows[i].b,
                       stim_rows[i].c, stim_rows[i].typed, stim_rows[i].res);
        end
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 81 : 0;
            snk_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 28 : 0;
            for (int k = 0; k < RAND_PER_PHASE; k++) send_random_query();
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("%0d tests checked across three handshake mixes", results_seen);
        $display("%0d reported inside, %0d with the point on an edge line",
                 inside_seen, on_line_seen);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/pit_pkg.sv
hw/rtl/point_in_triangle_test_top.sv
verif/tb_point_in_triangle_test_top.sv
